@@ design/pis_pkg.sv @@
// shared constants and types for the pid controller with integral separation
package pis_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int SP_W        = 16;
   localparam int GAIN_W      = 16;
   localparam int LIMIT_W     = 16;
   localparam int DRIVE_W     = 32;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_SET_POINT  = 3'd0;
   localparam csr_index_type CSR_GAIN_P     = 3'd1;
   localparam csr_index_type CSR_GAIN_I     = 3'd2;
   localparam csr_index_type CSR_GAIN_D     = 3'd3;
   localparam csr_index_type CSR_SEP_LIMIT  = 3'd4;
   localparam csr_index_type CSR_SEP_ENABLE = 3'd5;

   localparam logic [LIMIT_W-1:0] SEP_LIMIT_RESET = 16'hFFFF;

   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 32'sh8000_0000;

endpackage

@@ design/pis_req_if.sv @@
// request channel carrying one measured sample
interface pis_req_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] measurement;

   modport source (output valid, output measurement, input ready);
   modport sink   (input valid, input measurement, output ready);
endinterface

@@ design/pis_rsp_if.sv @@
// response channel carrying the drive value and its flags
interface pis_rsp_if
   import pis_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive;
   logic                      integrating;
   logic                      clipped;

   modport source (output valid, output drive, output integrating, output clipped,
                   input ready);
   modport sink   (input valid, input drive, input integrating, input clipped,
                   output ready);
endinterface

@@ design/pid_integral_separation.sv @@
// positional pid controller with integral separation, four-stage pipeline
// the only recurrence is the error sum add in stage one; a request passes the input,
// operand, product and output registers; throughput: one request per cycle unless
// the response stalls, which holds the pipeline; earlier stages keep filling their bubbles
// reset (synchronous, active high) empties the pipeline, clears the error history
// and loads the registers with sep_limit = 65535 and all others zero
module pid_integral_separation
   import pis_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int GAIN_FRAC_BITS = 8,
   parameter int SUM_WIDTH      = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   pis_req_if.sink                 req_bus,
   pis_rsp_if.source               rsp_bus,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int EW   = ((SAMPLE_WIDTH > SP_W) ? SAMPLE_WIDTH : SP_W) + 1;
   localparam int SX   = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1;
   localparam int PW_P = EW + GAIN_W + 1;
   localparam int PW_D = EW + GAIN_W + 2;
   localparam int PW_I = SUM_WIDTH + GAIN_W + 1;
   localparam int AW   = ((PW_I > PW_D) ? PW_I : PW_D) + 2;

   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   // configuration registers
   logic signed [SP_W-1:0]    set_point_ff;
   logic [GAIN_W-1:0]         gain_p_ff;
   logic [GAIN_W-1:0]         gain_i_ff;
   logic [GAIN_W-1:0]         gain_d_ff;
   logic [LIMIT_W-1:0]        sep_limit_ff;
   logic                      sep_enable_ff;
   logic                      csr_hit;

   // controller history
   logic signed [EW-1:0]        error_last_ff;
   logic signed [EW-1:0]        error_before_ff;
   logic signed [SUM_WIDTH-1:0] error_sum_ff;
   logic signed [SUM_WIDTH-1:0] error_sum_in;

   // stage valids and the ready chain
   logic v_in_ff, v_mul_ff, v_acc_ff, v_out_ff;
   logic rdy_out, rdy_acc, rdy_mul, rdy_in;
   logic adv_in, adv_mul, adv_acc;

   // stage one: input register and error path
   logic signed [SAMPLE_WIDTH-1:0] meas_ff;
   logic signed [EW-1:0]           err;
   logic [EW-1:0]                  err_mag;
   logic                           integ;
   logic signed [SX-1:0]           sum_wide;
   logic signed [SUM_WIDTH-1:0]    sum_sat;
   logic                           sum_clip;
   logic signed [EW:0]             derr;

   // stage two: multiplier operands
   logic signed [EW-1:0]        m_err_ff;
   logic signed [EW:0]          m_derr_ff;
   logic signed [SUM_WIDTH-1:0] m_sum_ff;
   logic                        m_integ_ff;
   logic                        m_clip_ff;

   // stage three: products
   logic signed [PW_P-1:0] prod_p_ff, prod_p_in;
   logic signed [PW_D-1:0] prod_d_ff, prod_d_in;
   logic signed [PW_I-1:0] prod_i_ff, prod_i_in;
   logic                   a_integ_ff;
   logic                   a_clip_ff;

   // stage four: output register
   logic signed [AW-1:0]      acc;
   logic signed [AW-1:0]      acc_shift;
   logic signed [DRIVE_W-1:0] drive_in, drive_ff;
   logic                      drive_clip;
   logic                      integ_out_ff;
   logic                      clip_out_ff;

   assign rdy_out = !v_out_ff || rsp_bus.ready;
   assign rdy_acc = !v_acc_ff || rdy_out;
   assign rdy_mul = !v_mul_ff || rdy_acc;
   assign rdy_in  = !v_in_ff  || rdy_mul;
   assign adv_acc = v_acc_ff && rdy_out;
   assign adv_mul = v_mul_ff && rdy_acc;
   assign adv_in  = v_in_ff  && rdy_mul;

   assign req_bus.ready = rdy_in;

   always_comb begin
      unique case (csr_index)
         CSR_SET_POINT, CSR_GAIN_P, CSR_GAIN_I, CSR_GAIN_D,
         CSR_SEP_LIMIT, CSR_SEP_ENABLE: csr_hit = csr_wr_en;
         default:                       csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_point_ff  <= '0;
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         sep_limit_ff  <= SEP_LIMIT_RESET;
         sep_enable_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SET_POINT:  set_point_ff  <= $signed(csr_wdata);
            CSR_GAIN_P:     gain_p_ff     <= csr_wdata;
            CSR_GAIN_I:     gain_i_ff     <= csr_wdata;
            CSR_GAIN_D:     gain_d_ff     <= csr_wdata;
            CSR_SEP_LIMIT:  sep_limit_ff  <= csr_wdata;
            CSR_SEP_ENABLE: sep_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stage one logic
   always_comb begin
      err      = EW'(set_point_ff) - EW'(meas_ff);
      // the most negative error negates to itself, which is still right read unsigned
      err_mag  = err[EW-1] ? EW'(-err) : EW'(err);
      integ    = !(sep_enable_ff && (err_mag > EW'(sep_limit_ff)));
      sum_wide = SX'(error_sum_ff) + SX'(err);
      sum_clip = 1'b0;
      if (sum_wide > SX'(SUM_MAX)) begin
         sum_sat  = SUM_MAX;
         sum_clip = 1'b1;
      end else if (sum_wide < SX'(SUM_MIN)) begin
         sum_sat  = SUM_MIN;
         sum_clip = 1'b1;
      end else begin
         sum_sat = sum_wide[SUM_WIDTH-1:0];
      end
      derr         = (EW+1)'(error_last_ff) - (EW+1)'(error_before_ff);
      error_sum_in = integ ? sum_sat : error_sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         error_last_ff   <= '0;
         error_before_ff <= '0;
         error_sum_ff    <= '0;
      end else if (adv_in) begin
         error_last_ff   <= err;
         error_before_ff <= error_last_ff;
         error_sum_ff    <= error_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && rdy_in) begin
         meas_ff <= req_bus.measurement;
      end
      if (adv_in) begin
         m_err_ff   <= err;
         m_derr_ff  <= derr;
         // a separated step contributes no integral term
         m_sum_ff   <= integ ? sum_sat : '0;
         m_integ_ff <= integ;
         m_clip_ff  <= integ && sum_clip;
      end
   end

   // stage two logic
   assign prod_p_in = PW_P'($signed({1'b0, gain_p_ff})) * PW_P'(m_err_ff);
   assign prod_d_in = PW_D'($signed({1'b0, gain_d_ff})) * PW_D'(m_derr_ff);
   assign prod_i_in = PW_I'($signed({1'b0, gain_i_ff})) * PW_I'(m_sum_ff);

   always_ff @(posedge clock) begin
      if (adv_mul) begin
         prod_p_ff  <= prod_p_in;
         prod_d_ff  <= prod_d_in;
         prod_i_ff  <= prod_i_in;
         a_integ_ff <= m_integ_ff;
         a_clip_ff  <= m_clip_ff;
      end
   end

   // stage three logic: exact sum, floor shift, clamp to the drive range
   always_comb begin
      acc        = AW'(prod_p_ff) + AW'(prod_d_ff) + AW'(prod_i_ff);
      acc_shift  = acc >>> GAIN_FRAC_BITS;
      drive_clip = 1'b0;
      if (acc_shift > AW'(DRIVE_MAX)) begin
         drive_in   = DRIVE_MAX;
         drive_clip = 1'b1;
      end else if (acc_shift < AW'(DRIVE_MIN)) begin
         drive_in   = DRIVE_MIN;
         drive_clip = 1'b1;
      end else begin
         drive_in = acc_shift[DRIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv_acc) begin
         drive_ff     <= drive_in;
         integ_out_ff <= a_integ_ff;
         clip_out_ff  <= a_clip_ff || drive_clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_in_ff  <= 1'b0;
         v_mul_ff <= 1'b0;
         v_acc_ff <= 1'b0;
         v_out_ff <= 1'b0;
      end else begin
         if (rdy_in)  v_in_ff  <= req_bus.valid;
         if (rdy_mul) v_mul_ff <= v_in_ff;
         if (rdy_acc) v_acc_ff <= v_mul_ff;
         if (rdy_out) v_out_ff <= v_acc_ff;
      end
   end

   assign rsp_bus.valid       = v_out_ff;
   assign rsp_bus.drive       = drive_ff;
   assign rsp_bus.integrating = integ_out_ff;
   assign rsp_bus.clipped     = clip_out_ff;

endmodule
